// ===== src/fgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgs_pkg
// Shared types and constants of the FASTA gap statistics unit.
// ----------------------------------------------------------------------------
package fgs_pkg;

   localparam int unsigned LEN_FIELD_BITS = 40;
   localparam int unsigned CNT_FIELD_BITS = 32;
   localparam int unsigned CSR_BITS       = 16;

   localparam logic [7:0] CHAR_N  = 8'h4E;
   localparam logic [7:0] CHAR_GT = 8'h3E;
   localparam logic [7:0] CHAR_NL = 8'h0A;

   localparam logic [CSR_BITS-1:0] MIN_GAP_RESET = 16'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [CNT_FIELD_BITS-1:0] scaffold_count;
      logic [CNT_FIELD_BITS-1:0] gapless_scaffolds;
      logic [LEN_FIELD_BITS-1:0] longest_scaffold;
      logic [LEN_FIELD_BITS-1:0] shortest_scaffold;
      logic [LEN_FIELD_BITS-1:0] total_scaffold_length;
      logic [CNT_FIELD_BITS-1:0] gap_count;
      logic [LEN_FIELD_BITS-1:0] shortest_gap;
      logic [LEN_FIELD_BITS-1:0] longest_gap;
      logic [LEN_FIELD_BITS-1:0] total_gap_length;
      logic [CNT_FIELD_BITS-1:0] fewest_gaps;
      logic [CNT_FIELD_BITS-1:0] most_gaps;
      logic [CNT_FIELD_BITS-1:0] gaps_in_gapped;
   } rsp_type;

   // events handed from the parser to the accumulators
   typedef struct packed {
      logic valid;    // a byte was taken
      logic gap;      // a qualifying gap ended
      logic close_a;  // a scaffold closed
      logic close_b;  // an extra empty scaffold closed (title opened on the last byte)
      logic last;     // end of file: report and clear
   } evt_type;

endpackage
`default_nettype wire

// ===== src/fgs_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgs_parser
// Byte parser: tracks title and sequence lines, the open scaffold and the
// open N run, and registers gap and scaffold-close events.
// ----------------------------------------------------------------------------
module fgs_parser import fgs_pkg::*; #(
   parameter int unsigned LENGTH_BITS = 40,
   parameter int unsigned COUNT_BITS  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   hold,
   input  wire req_type                req,
   input  wire logic [CSR_BITS-1:0]    min_gap_size,
   output evt_type                     evt,
   output logic [LENGTH_BITS-1:0]      gap_len,
   output logic [LENGTH_BITS-1:0]      scf_len,
   output logic [COUNT_BITS-1:0]       scf_gaps
);

   typedef enum logic [1:0] {
      MODE_PREAMBLE,
      MODE_TITLE,
      MODE_SEQ
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic                   in_gap_ff, in_gap_in;
   logic [LENGTH_BITS-1:0] glen_ff, glen_in;
   logic [LENGTH_BITS-1:0] slen_ff, slen_in;
   logic [COUNT_BITS-1:0]  gthis_ff, gthis_in;

   evt_type                evt_ff, evt_in;
   logic [LENGTH_BITS-1:0] gap_len_ff, gap_len_in;
   logic [LENGTH_BITS-1:0] scf_len_ff, scf_len_in;
   logic [COUNT_BITS-1:0]  scf_gaps_ff, scf_gaps_in;

   logic [LENGTH_BITS-1:0] min_ext;
   logic [7:0]             b;

   function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + LENGTH_BITS'(1);
   endfunction

   function automatic logic [COUNT_BITS-1:0] inc_cnt(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + COUNT_BITS'(1);
   endfunction

   assign min_ext = LENGTH_BITS'(min_gap_size);
   assign b       = req.data_byte;

   always_comb begin
      mode_in     = mode_ff;
      in_gap_in   = in_gap_ff;
      glen_in     = glen_ff;
      slen_in     = slen_ff;
      gthis_in    = gthis_ff;
      evt_in      = '0;
      evt_in.valid = accept;
      evt_in.last  = req.final_byte;
      gap_len_in  = glen_ff;
      scf_len_in  = slen_ff;
      scf_gaps_in = gthis_ff;

      unique case (mode_ff)
         MODE_PREAMBLE: begin
            if (b == CHAR_GT) mode_in = MODE_TITLE;
         end
         MODE_TITLE: begin
            if (b == CHAR_NL) mode_in = MODE_SEQ;
         end
         MODE_SEQ: begin
            if (in_gap_ff && b != CHAR_N && b != CHAR_NL) begin
               evt_in.gap = glen_ff >= min_ext;
               gap_len_in = glen_ff;
               if (evt_in.gap) gthis_in = inc_cnt(gthis_ff);
               glen_in   = '0;
               in_gap_in = 1'b0;
            end
            if (b == CHAR_GT) begin
               evt_in.close_a = 1'b1;
               scf_len_in     = slen_ff;
               scf_gaps_in    = gthis_in;
               mode_in        = MODE_TITLE;
               slen_in        = '0;
               gthis_in       = '0;
            end else if (b == CHAR_N) begin
               in_gap_in = 1'b1;
               glen_in   = inc_len(glen_ff);
               slen_in   = inc_len(slen_ff);
            end else if (b != CHAR_NL) begin
               slen_in = inc_len(slen_ff);
            end
         end
         default: mode_in = MODE_PREAMBLE;
      endcase

      if (req.final_byte) begin
         if (in_gap_in) begin
            evt_in.gap = glen_in >= min_ext;
            gap_len_in = glen_in;
            if (evt_in.gap) gthis_in = inc_cnt(gthis_in);
         end
         if (mode_in != MODE_PREAMBLE) begin
            if (evt_in.close_a) begin
               evt_in.close_b = 1'b1;
            end else begin
               evt_in.close_a = 1'b1;
               scf_len_in     = slen_in;
               scf_gaps_in    = gthis_in;
            end
         end
         mode_in   = MODE_PREAMBLE;
         in_gap_in = 1'b0;
         glen_in   = '0;
         slen_in   = '0;
         gthis_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PREAMBLE;
         in_gap_ff <= 1'b0;
         glen_ff   <= '0;
         slen_ff   <= '0;
         gthis_ff  <= '0;
         evt_ff    <= '0;
      end else if (!hold) begin
         evt_ff      <= evt_in;
         gap_len_ff  <= gap_len_in;
         scf_len_ff  <= scf_len_in;
         scf_gaps_ff <= scf_gaps_in;
         if (accept) begin
            mode_ff   <= mode_in;
            in_gap_ff <= in_gap_in;
            glen_ff   <= glen_in;
            slen_ff   <= slen_in;
            gthis_ff  <= gthis_in;
         end
      end
   end

   assign evt      = evt_ff;
   assign gap_len  = gap_len_ff;
   assign scf_len  = scf_len_ff;
   assign scf_gaps = scf_gaps_ff;

endmodule
`default_nettype wire

// ===== src/fgs_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgs_accum
// Statistics accumulators: counts, minima, maxima and saturating totals of
// gaps and scaffolds. Presents the updated totals and clears on end of file.
// ----------------------------------------------------------------------------
module fgs_accum import fgs_pkg::*; #(
   parameter int unsigned LENGTH_BITS = 40,
   parameter int unsigned COUNT_BITS  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   hold,
   input  wire evt_type                evt,
   input  wire logic [LENGTH_BITS-1:0] gap_len,
   input  wire logic [LENGTH_BITS-1:0] scf_len,
   input  wire logic [COUNT_BITS-1:0]  scf_gaps,
   output rsp_type                     totals
);

   logic [COUNT_BITS-1:0]  scf_cnt_ff, scf_cnt_in, scf_cnt_up;
   logic [COUNT_BITS-1:0]  gapless_ff, gapless_in, gapless_up;
   logic [LENGTH_BITS-1:0] max_scf_ff, max_scf_in, max_scf_up;
   logic [LENGTH_BITS-1:0] min_scf_ff, min_scf_in, min_scf_up;
   logic                   min_scf_ok_ff, min_scf_ok_in, min_scf_ok_up;
   logic [LENGTH_BITS-1:0] sum_scf_ff, sum_scf_in, sum_scf_up;
   logic [COUNT_BITS-1:0]  gap_cnt_ff, gap_cnt_in, gap_cnt_up;
   logic [LENGTH_BITS-1:0] min_gap_ff, min_gap_in, min_gap_up;
   logic                   min_gap_ok_ff, min_gap_ok_in, min_gap_ok_up;
   logic [LENGTH_BITS-1:0] max_gap_ff, max_gap_in, max_gap_up;
   logic [LENGTH_BITS-1:0] sum_gap_ff, sum_gap_in, sum_gap_up;
   logic [COUNT_BITS-1:0]  min_per_ff, min_per_in, min_per_up;
   logic                   min_per_ok_ff, min_per_ok_in, min_per_ok_up;
   logic [COUNT_BITS-1:0]  max_per_ff, max_per_in, max_per_up;
   logic [COUNT_BITS-1:0]  sum_per_ff, sum_per_in, sum_per_up;

   logic                   gapped;
   logic [1:0]             scf_step;
   logic [1:0]             gapless_step;
   logic                   take;

   function automatic logic [LENGTH_BITS-1:0] add_len(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [LENGTH_BITS-1:0] c);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + {1'b0, c};
      return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] add_cnt(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, c};
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   assign take   = evt.valid && !hold;
   assign gapped = scf_gaps != '0;
   assign scf_step     = {1'b0, evt.close_a} + {1'b0, evt.close_b};
   assign gapless_step = {1'b0, evt.close_a && !gapped} + {1'b0, evt.close_b};

   always_comb begin
      scf_cnt_up    = add_cnt(scf_cnt_ff, COUNT_BITS'(scf_step));
      gapless_up    = add_cnt(gapless_ff, COUNT_BITS'(gapless_step));
      max_scf_up    = max_scf_ff;
      min_scf_up    = min_scf_ff;
      min_scf_ok_up = min_scf_ok_ff;
      sum_scf_up    = sum_scf_ff;
      min_per_up    = min_per_ff;
      min_per_ok_up = min_per_ok_ff;
      max_per_up    = max_per_ff;
      sum_per_up    = sum_per_ff;
      if (evt.close_a) begin
         if (!min_scf_ok_ff || scf_len < min_scf_ff) begin
            min_scf_up    = scf_len;
            min_scf_ok_up = 1'b1;
         end
         if (scf_len > max_scf_ff) max_scf_up = scf_len;
         sum_scf_up = add_len(sum_scf_ff, scf_len);
         if (gapped) begin
            if (!min_per_ok_ff || scf_gaps < min_per_ff) begin
               min_per_up    = scf_gaps;
               min_per_ok_up = 1'b1;
            end
            if (scf_gaps > max_per_ff) max_per_up = scf_gaps;
            sum_per_up = add_cnt(sum_per_ff, scf_gaps);
         end
      end
      if (evt.close_b) begin
         min_scf_up    = '0;
         min_scf_ok_up = 1'b1;
      end

      gap_cnt_up    = gap_cnt_ff;
      min_gap_up    = min_gap_ff;
      min_gap_ok_up = min_gap_ok_ff;
      max_gap_up    = max_gap_ff;
      sum_gap_up    = sum_gap_ff;
      if (evt.gap) begin
         gap_cnt_up = (&gap_cnt_ff) ? gap_cnt_ff : gap_cnt_ff + COUNT_BITS'(1);
         if (!min_gap_ok_ff || gap_len < min_gap_ff) begin
            min_gap_up    = gap_len;
            min_gap_ok_up = 1'b1;
         end
         if (gap_len > max_gap_ff) max_gap_up = gap_len;
         sum_gap_up = add_len(sum_gap_ff, gap_len);
      end
   end

   always_comb begin
      if (evt.last) begin
         scf_cnt_in    = '0;
         gapless_in    = '0;
         max_scf_in    = '0;
         min_scf_in    = '0;
         min_scf_ok_in = 1'b0;
         sum_scf_in    = '0;
         gap_cnt_in    = '0;
         min_gap_in    = '0;
         min_gap_ok_in = 1'b0;
         max_gap_in    = '0;
         sum_gap_in    = '0;
         min_per_in    = '0;
         min_per_ok_in = 1'b0;
         max_per_in    = '0;
         sum_per_in    = '0;
      end else begin
         scf_cnt_in    = scf_cnt_up;
         gapless_in    = gapless_up;
         max_scf_in    = max_scf_up;
         min_scf_in    = min_scf_up;
         min_scf_ok_in = min_scf_ok_up;
         sum_scf_in    = sum_scf_up;
         gap_cnt_in    = gap_cnt_up;
         min_gap_in    = min_gap_up;
         min_gap_ok_in = min_gap_ok_up;
         max_gap_in    = max_gap_up;
         sum_gap_in    = sum_gap_up;
         min_per_in    = min_per_up;
         min_per_ok_in = min_per_ok_up;
         max_per_in    = max_per_up;
         sum_per_in    = sum_per_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scf_cnt_ff    <= '0;
         gapless_ff    <= '0;
         max_scf_ff    <= '0;
         min_scf_ff    <= '0;
         min_scf_ok_ff <= 1'b0;
         sum_scf_ff    <= '0;
         gap_cnt_ff    <= '0;
         min_gap_ff    <= '0;
         min_gap_ok_ff <= 1'b0;
         max_gap_ff    <= '0;
         sum_gap_ff    <= '0;
         min_per_ff    <= '0;
         min_per_ok_ff <= 1'b0;
         max_per_ff    <= '0;
         sum_per_ff    <= '0;
      end else if (take) begin
         scf_cnt_ff    <= scf_cnt_in;
         gapless_ff    <= gapless_in;
         max_scf_ff    <= max_scf_in;
         min_scf_ff    <= min_scf_in;
         min_scf_ok_ff <= min_scf_ok_in;
         sum_scf_ff    <= sum_scf_in;
         gap_cnt_ff    <= gap_cnt_in;
         min_gap_ff    <= min_gap_in;
         min_gap_ok_ff <= min_gap_ok_in;
         max_gap_ff    <= max_gap_in;
         sum_gap_ff    <= sum_gap_in;
         min_per_ff    <= min_per_in;
         min_per_ok_ff <= min_per_ok_in;
         max_per_ff    <= max_per_in;
         sum_per_ff    <= sum_per_in;
      end
   end

   always_comb begin
      totals.scaffold_count        = CNT_FIELD_BITS'(scf_cnt_up);
      totals.gapless_scaffolds     = CNT_FIELD_BITS'(gapless_up);
      totals.longest_scaffold      = LEN_FIELD_BITS'(max_scf_up);
      totals.shortest_scaffold     = min_scf_ok_up ? LEN_FIELD_BITS'(min_scf_up) : '0;
      totals.total_scaffold_length = LEN_FIELD_BITS'(sum_scf_up);
      totals.gap_count             = CNT_FIELD_BITS'(gap_cnt_up);
      totals.shortest_gap          = min_gap_ok_up ? LEN_FIELD_BITS'(min_gap_up) : '0;
      totals.longest_gap           = LEN_FIELD_BITS'(max_gap_up);
      totals.total_gap_length      = LEN_FIELD_BITS'(sum_gap_up);
      totals.fewest_gaps           = min_per_ok_up ? CNT_FIELD_BITS'(min_per_up) : '0;
      totals.most_gaps             = CNT_FIELD_BITS'(max_per_up);
      totals.gaps_in_gapped        = CNT_FIELD_BITS'(sum_per_up);
   end

endmodule
`default_nettype wire

// ===== src/fasta_gap_statistics_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fasta_gap_statistics_unit
// Scaffold and gap statistics over a FASTA file streamed one byte per
// transaction; one result transaction follows each byte marked final.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_type: data_byte, final_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_type: twelve totals
//   csr      in         csr_write_enable       csr_write_data: min_gap_size
//
// One byte per cycle unless stalled. Results pass evt_ff, then rsp_payload_ff.
// Reset clears all statistics and sets min_gap_size to 1.
// req_stall rises only when a final byte is ready to report while an earlier
// result is still held and stalled.
// ----------------------------------------------------------------------------
module fasta_gap_statistics_unit import fgs_pkg::*; #(
   parameter int unsigned LENGTH_BITS = 40,
   parameter int unsigned COUNT_BITS  = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload,
   input  wire logic                csr_write_enable,
   input  wire logic [CSR_BITS-1:0] csr_write_data
);

   logic [CSR_BITS-1:0]    min_gap_ff;
   logic                   accept;
   logic                   blocked;
   logic                   fire;
   evt_type                evt;
   logic [LENGTH_BITS-1:0] gap_len;
   logic [LENGTH_BITS-1:0] scf_len;
   logic [COUNT_BITS-1:0]  scf_gaps;
   rsp_type                totals;
   logic                   rsp_valid_ff;
   rsp_type                rsp_payload_ff;

   assign blocked   = evt.valid && evt.last && rsp_valid_ff && rsp_stall;
   assign req_stall = blocked;
   assign accept    = req_valid && !blocked;
   assign fire      = evt.valid && evt.last && !blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff <= MIN_GAP_RESET;
      end else if (csr_write_enable) begin
         min_gap_ff <= csr_write_data;
      end
   end

   fgs_parser #(
      .LENGTH_BITS(LENGTH_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .hold        (blocked),
      .req         (req_payload),
      .min_gap_size(min_gap_ff),
      .evt         (evt),
      .gap_len     (gap_len),
      .scf_len     (scf_len),
      .scf_gaps    (scf_gaps)
   );

   fgs_accum #(
      .LENGTH_BITS(LENGTH_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .hold    (blocked),
      .evt     (evt),
      .gap_len (gap_len),
      .scf_len (scf_len),
      .scf_gaps(scf_gaps),
      .totals  (totals)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_payload_ff <= totals;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ===== sim/fasta_gap_statistics_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_gap_statistics_unit_test
// Self-checking bench for the FASTA gap statistics unit.
// Streams short sequence files byte by byte, mostly well-formed files with
// random titles, bases, N runs and line breaks, plus some raw noise. A
// scoreboard tracks the parser and the statistics per byte and checks every
// result transaction field by field. Random sender gaps and receiver stalls
// are applied, and min_gap_size is varied between phases.
// ----------------------------------------------------------------------------
module fasta_gap_statistics_unit_test;
   import fgs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [LEN_FIELD_BITS-1:0] LEN_TOP = {LEN_FIELD_BITS{1'b1}};
   localparam logic [CNT_FIELD_BITS-1:0] CNT_TOP = {CNT_FIELD_BITS{1'b1}};

   typedef enum logic [1:0] {FILE_PREAMBLE, FILE_TITLE, FILE_SEQUENCE} file_mode_type;
   typedef logic [7:0] file_bytes_type[$];

   class gap_tally_board;
      logic [CSR_BITS-1:0]       min_gap;
      file_mode_type             mode;
      bit                        in_gap;
      logic [LEN_FIELD_BITS-1:0] scaf_len, gap_len;
      logic [CNT_FIELD_BITS-1:0] gaps_here;
      logic [CNT_FIELD_BITS-1:0] scaf_count, gapless, gap_count;
      logic [LEN_FIELD_BITS-1:0] max_scaf, min_scaf, sum_scaf;
      logic [LEN_FIELD_BITS-1:0] max_gap, min_gap_len, sum_gap;
      logic [CNT_FIELD_BITS-1:0] min_per, max_per, sum_per;
      bit                        min_scaf_ok, min_gap_ok, min_per_ok;
      rsp_type                   expected_q[$];
      int                        failures;
      int                        records;

      function new();
         min_gap  = MIN_GAP_RESET;
         failures = 0;
         records  = 0;
         clear();
      endfunction

      function void clear();
         mode       = FILE_PREAMBLE;
         in_gap     = 0;
         scaf_len   = '0;
         gap_len    = '0;
         gaps_here  = '0;
         scaf_count = '0;
         gapless    = '0;
         gap_count  = '0;
         max_scaf   = '0;
         min_scaf   = '0;
         sum_scaf   = '0;
         max_gap    = '0;
         min_gap_len = '0;
         sum_gap    = '0;
         min_per    = '0;
         max_per    = '0;
         sum_per    = '0;
         min_scaf_ok = 0;
         min_gap_ok  = 0;
         min_per_ok  = 0;
      endfunction

      function logic [LEN_FIELD_BITS-1:0] len_inc(logic [LEN_FIELD_BITS-1:0] v);
         return (v == LEN_TOP) ? v : v + LEN_FIELD_BITS'(1);
      endfunction

      function logic [CNT_FIELD_BITS-1:0] cnt_inc(logic [CNT_FIELD_BITS-1:0] v);
         return (v == CNT_TOP) ? v : v + CNT_FIELD_BITS'(1);
      endfunction

      function logic [LEN_FIELD_BITS-1:0] len_add(logic [LEN_FIELD_BITS-1:0] a,
                                                  logic [LEN_FIELD_BITS-1:0] b);
         logic [LEN_FIELD_BITS:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[LEN_FIELD_BITS] ? LEN_TOP : s[LEN_FIELD_BITS-1:0];
      endfunction

      function logic [CNT_FIELD_BITS-1:0] cnt_add(logic [CNT_FIELD_BITS-1:0] a,
                                                  logic [CNT_FIELD_BITS-1:0] b);
         logic [CNT_FIELD_BITS:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[CNT_FIELD_BITS] ? CNT_TOP : s[CNT_FIELD_BITS-1:0];
      endfunction

      function void close_gap();
         if (gap_len >= min_gap) begin
            gap_count = cnt_inc(gap_count);
            gaps_here = cnt_inc(gaps_here);
            if (!min_gap_ok || gap_len < min_gap_len) begin
               min_gap_len = gap_len;
               min_gap_ok  = 1;
            end
            if (gap_len > max_gap) max_gap = gap_len;
            sum_gap = len_add(sum_gap, gap_len);
         end
         gap_len = '0;
         in_gap  = 0;
      endfunction

      function void close_scaffold();
         scaf_count = cnt_inc(scaf_count);
         if (gaps_here != 0) begin
            if (!min_per_ok || gaps_here < min_per) begin
               min_per    = gaps_here;
               min_per_ok = 1;
            end
            if (gaps_here > max_per) max_per = gaps_here;
            sum_per = cnt_add(sum_per, gaps_here);
         end else begin
            gapless = cnt_inc(gapless);
         end
         if (!min_scaf_ok || scaf_len < min_scaf) begin
            min_scaf    = scaf_len;
            min_scaf_ok = 1;
         end
         if (scaf_len > max_scaf) max_scaf = scaf_len;
         sum_scaf  = len_add(sum_scaf, scaf_len);
         gaps_here = '0;
         scaf_len  = '0;
      endfunction

      // one accepted input transaction
      function void note_byte(logic [7:0] b, logic fin);
         rsp_type r;
         case (mode)
            FILE_PREAMBLE: begin
               if (b == CHAR_GT) mode = FILE_TITLE;
            end
            FILE_TITLE: begin
               if (b == CHAR_NL) mode = FILE_SEQUENCE;
            end
            default: begin
               if (in_gap && b != CHAR_N && b != CHAR_NL) close_gap();
               if (b == CHAR_GT) begin
                  close_scaffold();
                  mode = FILE_TITLE;
               end else if (b == CHAR_N) begin
                  in_gap   = 1;
                  gap_len  = len_inc(gap_len);
                  scaf_len = len_inc(scaf_len);
               end else if (b != CHAR_NL) begin
                  scaf_len = len_inc(scaf_len);
               end
            end
         endcase
         if (!fin) return;
         if (in_gap) close_gap();
         if (mode != FILE_PREAMBLE) close_scaffold();
         r.scaffold_count        = scaf_count;
         r.gapless_scaffolds     = gapless;
         r.longest_scaffold      = max_scaf;
         r.shortest_scaffold     = min_scaf_ok ? min_scaf : '0;
         r.total_scaffold_length = sum_scaf;
         r.gap_count             = gap_count;
         r.shortest_gap          = min_gap_ok ? min_gap_len : '0;
         r.longest_gap           = max_gap;
         r.total_gap_length      = sum_gap;
         r.fewest_gaps           = min_per_ok ? min_per : '0;
         r.most_gaps             = max_per;
         r.gaps_in_gapped        = sum_per;
         expected_q.push_back(r);
         clear();
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void cmp(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            failures++;
         end
      endfunction

      // one accepted result transaction
      function void check_record(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         records++;
         cmp("scaffold_count", e.scaffold_count, got.scaffold_count);
         cmp("gapless_scaffolds", e.gapless_scaffolds, got.gapless_scaffolds);
         cmp("longest_scaffold", e.longest_scaffold, got.longest_scaffold);
         cmp("shortest_scaffold", e.shortest_scaffold, got.shortest_scaffold);
         cmp("total_scaffold_length", e.total_scaffold_length, got.total_scaffold_length);
         cmp("gap_count", e.gap_count, got.gap_count);
         cmp("shortest_gap", e.shortest_gap, got.shortest_gap);
         cmp("longest_gap", e.longest_gap, got.longest_gap);
         cmp("total_gap_length", e.total_gap_length, got.total_gap_length);
         cmp("fewest_gaps", e.fewest_gaps, got.fewest_gaps);
         cmp("most_gaps", e.most_gaps, got.most_gaps);
         cmp("gaps_in_gapped", e.gaps_in_gapped, got.gaps_in_gapped);
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   req_type             req_payload      = '0;
   logic                rsp_stall        = 1'b0;
   logic                csr_write_enable = 1'b0;
   logic [CSR_BITS-1:0] csr_write_data   = '0;
   logic                req_stall;
   logic                rsp_valid;
   rsp_type             rsp_payload;

   gap_tally_board board = new();
   int                  sender_idle_pct    = 15;
   int                  receiver_stall_pct = 85;
   int unsigned         cycle_count        = 0;
   int                  bytes_sent         = 0;
   int                  files_sent         = 0;

   fasta_gap_statistics_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: sample the transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_record(rsp_payload);
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, final_byte: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_file(input file_bytes_type f);
      for (int i = 0; i < f.size(); i++) push_byte(f[i], i == f.size() - 1);
      files_sent++;
   endtask

   task automatic write_min_gap(input logic [CSR_BITS-1:0] v);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.min_gap = v;
   endtask

   function automatic file_bytes_type from_text(string s);
      file_bytes_type f;
      for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
      return f;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(3))
         0:       return CHAR_N;
         1:       return CHAR_NL;
         2:       return CHAR_GT;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic file_bytes_type random_file();
      file_bytes_type f;
      int          scafs;
      string       bases = "ACGT";
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(30, 1)) f.push_back(noise_byte());
         return f;
      end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(4, 1)) f.push_back(8'($urandom_range(255)));
      scafs = $urandom_range(3, 1);
      for (int s = 0; s < scafs; s++) begin
         f.push_back(CHAR_GT);
         repeat ($urandom_range(5))
            f.push_back(($urandom_range(9) == 0) ? CHAR_GT : 8'($urandom_range(126, 33)));
         if (s == scafs - 1 && $urandom_range(19) == 0) return f;
         f.push_back(CHAR_NL);
         repeat ($urandom_range(5)) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  repeat ($urandom_range(8, 1)) begin
                     f.push_back(CHAR_N);
                     if ($urandom_range(5) == 0) f.push_back(CHAR_NL);
                  end
               end
               4, 5, 6: repeat ($urandom_range(6, 1)) f.push_back(bases[$urandom_range(3)]);
               7:       f.push_back(CHAR_NL);
               8: begin
                  f.push_back(8'h0D);
                  f.push_back(CHAR_NL);
               end
               default: f.push_back(noise_byte());
            endcase
         end
      end
      return f;
   endfunction

   initial begin
      file_bytes_type      f;
      logic [CSR_BITS-1:0] gap_settings [6];
      int                  phase_bytes;
      int                  phase_files;

      gap_settings[0] = 16'd0;
      gap_settings[1] = 16'd3;
      gap_settings[2] = 16'hFFFF;
      gap_settings[3] = 16'($urandom_range(8));
      gap_settings[4] = 16'd2;
      gap_settings[5] = 16'($urandom_range(65535));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // end of file before any title: all zero
      f = '{8'h00};
      send_file(f);
      // nested title marker, gap across a newline, 0xFF base, title on last byte
      f = from_text(">>\nN\nNx");
      f.push_back(8'hFF);
      f.push_back(CHAR_GT);
      send_file(f);
      // preamble byte, gap running into end of file
      f = from_text("z>t\nAN");
      send_file(f);
      // end inside a title line, carriage return as a base
      f = from_text(">\nC\r>ti");
      send_file(f);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            sender_idle_pct    = 85;
            receiver_stall_pct = 15;
         end else if (ph == 4) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         write_min_gap(gap_settings[ph]);
         phase_bytes = 0;
         phase_files = 0;
         while (phase_bytes < 130 || phase_files < 3) begin
            f = random_file();
            send_file(f);
            phase_bytes += f.size();
            phase_files++;
         end
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Streamed %0d bytes in %0d files; %0d statistics records checked.",
               bytes_sent, files_sent, board.records);
      $display("min_gap_size settings: 1, 0, 3, 65535, %0d, 2, %0d.",
               gap_settings[3], gap_settings[5]);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
